### rtl/encoder_button_menu_controller_top_defines.svh
// Assertion macros shared by the menu controller RTL.
`ifndef ENCODER_BUTTON_MENU_CONTROLLER_TOP_DEFINES_SVH
`define ENCODER_BUTTON_MENU_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clk outside reset
`define EBMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clk outside reset
`define EBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ebmc_pkg.sv
// Types, constants and lookup functions of the encoder/button menu controller.
package ebmc_pkg;

    localparam int MENU_ENTRIES = 12;
    localparam int HELD_SLOTS   = 9;

    localparam logic [3:0] LAST_ENTRY   = 4'(MENU_ENTRIES - 1);
    localparam logic [7:0] VALUE_MAX    = 8'd255;
    localparam logic [7:0] DIM_LEVEL    = 8'd40;
    localparam logic [7:0] PRESET_LIMIT = 8'd250;

    // Menu entry codes
    localparam logic [3:0] ENTRY_BRIGHT    = 4'd0;
    localparam logic [3:0] ENTRY_SPEED     = 4'd1;
    localparam logic [3:0] ENTRY_INTENSITY = 4'd2;
    localparam logic [3:0] ENTRY_PALETTE   = 4'd3;
    localparam logic [3:0] ENTRY_EFFECT    = 4'd4;
    localparam logic [3:0] ENTRY_HUE       = 4'd5;
    localparam logic [3:0] ENTRY_SAT       = 4'd6;
    localparam logic [3:0] ENTRY_CCT       = 4'd7;
    localparam logic [3:0] ENTRY_PRESET    = 4'd8;
    localparam logic [3:0] ENTRY_CUSTOM1   = 4'd9;
    localparam logic [3:0] ENTRY_CUSTOM2   = 4'd10;
    localparam logic [3:0] ENTRY_CUSTOM3   = 4'd11;

    // Configuration register indexes
    localparam logic [2:0] REG_LONG_MS     = 3'd0;
    localparam logic [2:0] REG_WINDOW_MS   = 3'd1;
    localparam logic [2:0] REG_STEP        = 3'd2;
    localparam logic [2:0] REG_LAST_STATE  = 3'd3;
    localparam logic [2:0] REG_PRESET_LOW  = 3'd4;
    localparam logic [2:0] REG_PRESET_HIGH = 3'd5;

    // Reset levels of the held values, slot order:
    // brightness, speed, intensity, hue, saturation, cct, custom1..3
    localparam logic [7:0] HELD_INIT [HELD_SLOTS] =
        '{8'd128, 8'd128, 8'd128, 8'd16, 8'd255, 8'd128, 8'd128, 8'd128, 8'd128};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BTN,
        ST_WAIT,
        ST_SEARCH,
        ST_DELTA,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] long_ms;
        logic [15:0] window_ms;
        logic [6:0]  step;
        logic [3:0]  last_state;
        logic [7:0]  preset_low;
        logic [7:0]  preset_high;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
        logic [31:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [32:0] res;   // bit 32 is the borrow of a subtraction
        logic        gt;    // res[31:0] > limit
    } alu_rsp_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } slot_t;

    // Held-value slot of a menu entry; invalid for request-only entries
    function automatic slot_t held_slot(input logic [3:0] e);
        slot_t s;
        s.valid = 1'b1;
        s.idx   = 4'd0;
        case (e)
            ENTRY_BRIGHT:    s.idx = 4'd0;
            ENTRY_SPEED:     s.idx = 4'd1;
            ENTRY_INTENSITY: s.idx = 4'd2;
            ENTRY_HUE:       s.idx = 4'd3;
            ENTRY_SAT:       s.idx = 4'd4;
            ENTRY_CCT:       s.idx = 4'd5;
            ENTRY_CUSTOM1:   s.idx = 4'd6;
            ENTRY_CUSTOM2:   s.idx = 4'd7;
            ENTRY_CUSTOM3:   s.idx = 4'd8;
            default:         s.valid = 1'b0;
        endcase
        return s;
    endfunction

    // Whether a menu entry can be selected with the current flags
    function automatic logic entry_avail(input logic [3:0] e, input logic [4:0] sliders,
                                         input logic cct, input logic preset_on);
        logic ok;
        ok = 1'b1;
        case (e)
            ENTRY_SPEED:     ok = sliders[0];
            ENTRY_INTENSITY: ok = sliders[1];
            ENTRY_CCT:       ok = cct;
            ENTRY_PRESET:    ok = preset_on;
            ENTRY_CUSTOM1:   ok = sliders[2];
            ENTRY_CUSTOM2:   ok = sliders[3];
            ENTRY_CUSTOM3:   ok = sliders[4];
            default:         ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

### rtl/ebmc_cfg.sv
// Configuration register bank with preset clamping.
module ebmc_cfg
    import ebmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Preset limits saturate at the top preset number
    logic [7:0] preset_val;
    assign preset_val = (cfg_data[7:0] > PRESET_LIMIT) ? PRESET_LIMIT : cfg_data[7:0];

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_MS:     cfg_next.long_ms     = cfg_data;
                REG_WINDOW_MS:   cfg_next.window_ms   = cfg_data;
                REG_STEP:        cfg_next.step        = cfg_data[6:0];
                REG_LAST_STATE:  cfg_next.last_state  = cfg_data[3:0];
                REG_PRESET_LOW:  cfg_next.preset_low  = preset_val;
                REG_PRESET_HIGH: cfg_next.preset_high = preset_val;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_ms     <= 16'd3000;
            cfg_reg.window_ms   <= 16'd350;
            cfg_reg.step        <= 7'd5;
            cfg_reg.last_state  <= 4'd11;
            cfg_reg.preset_low  <= 8'd0;
            cfg_reg.preset_high <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/ebmc_alu.sv
// Shared add/subtract unit with a compare against a limit.
module ebmc_alu
    import ebmc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    // 33-bit add or subtract; the top bit flags a carry or borrow
    always_comb
    begin
        if (req.sub)
        begin
            rsp.res = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            rsp.res = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.gt = rsp.res[31:0] > req.limit;
    end

endmodule

### rtl/encoder_button_menu_controller_top.sv
// Top level: poll sequencer, button/encoder state and output register.
// A poll runs the button, window and delta states to m_tvalid, with a held-value
// step for entries that hold one and, on a menu advance, a search, one entry per
// cycle. One item is in work at a time: the next is taken in the cycle after the
// result is loaded, and time, count and step arithmetic uses the one shared
// add/compare unit, one operation per cycle. A baseline load skips to the result.
// rst_n (asynchronous, active low) restores registers, held values and state.
`include "encoder_button_menu_controller_top_defines.svh"

module encoder_button_menu_controller_top
    import ebmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] button_pressed, [48:33] encoder_count,
    // [53:49] slider_mask, [54] cct_capable, [55] zero
    input  logic [55:0] s_tdata,
    // [0] action
    input  logic        s_tuser,
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] menu_index, [4] menu_changed, [5] long_press, [6] toggle_power,
    // [7] adjust_valid, [8] adjust_up, [12:9] adjust_target, [20:13] adjust_value,
    // [23:21] zero
    output logic [23:0] m_tdata,
    // [0] value_held
    output logic        m_tuser
);

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    ebmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ebmc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cfg_ready = 1'b1;

    // Sequencer and item latches
    state_t      state_reg, state_next;
    logic        act_reg, act_next;
    logic [31:0] now_reg, now_next;
    logic        pressed_reg, pressed_next;
    logic [15:0] count_reg, count_next;
    logic [4:0]  sliders_reg, sliders_next;
    logic        cct_reg, cct_next;

    // Persistent controller state
    logic [15:0] prev_count_reg, prev_count_next;
    logic        press_active_reg, press_active_next;
    logic        long_rep_reg, long_rep_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        wait_active_reg, wait_active_next;
    logic [31:0] wait_start_reg, wait_start_next;
    logic [3:0]  sel_reg, sel_next;
    logic [7:0]  held_reg [HELD_SLOTS];
    logic [7:0]  held_next [HELD_SLOTS];

    // Per-item scratch
    logic [3:0]  e_reg, e_next;
    logic        inc_reg, inc_next;
    logic        res_changed_reg, res_changed_next;
    logic        res_long_reg, res_long_next;
    logic        res_toggle_reg, res_toggle_next;
    logic        res_valid_reg, res_valid_next;
    logic        res_up_reg, res_up_next;
    logic [7:0]  res_value_reg, res_value_next;
    logic        res_held_reg, res_held_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [20:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;

    // Derived configuration terms
    logic [3:0] last_eff;
    logic       preset_on;
    logic       preset_step_ok;
    assign last_eff       = (cfg.last_state > LAST_ENTRY) ? LAST_ENTRY : cfg.last_state;
    assign preset_on      = (cfg.preset_high != 8'd0) && (cfg.preset_low != 8'd0);
    assign preset_step_ok = preset_on && (cfg.preset_high > cfg.preset_low);

    // Search step, step amount and slot lookup
    logic [3:0] e_adv;
    logic [3:0] e_wrap;
    logic       e_taken;
    logic [6:0] amount;
    slot_t      slot;
    logic [15:0] diff;
    logic [7:0] step_val;

    assign e_taken = (e_reg <= LAST_ENTRY) && entry_avail(e_reg, sliders_reg, cct_reg, preset_on);
    assign e_adv   = ((e_reg > LAST_ENTRY) || e_taken) ? e_reg : e_reg + 4'd1;
    assign e_wrap  = (e_adv > last_eff) ? 4'd0 : e_adv;
    assign slot    = held_slot(sel_reg);
    assign amount  = ((sel_reg == ENTRY_BRIGHT) && (held_reg[0] < DIM_LEVEL)) ?
                     {1'b0, cfg.step[6:1]} : cfg.step;
    assign diff    = alu_rsp.res[15:0];
    // Saturate the shared unit's sum or difference to the value range
    assign step_val = (!inc_reg && alu_rsp.res[32]) ? 8'd0 :
                      ( inc_reg && alu_rsp.gt)      ? VALUE_MAX : alu_rsp.res[7:0];

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        act_next          = act_reg;
        now_next          = now_reg;
        pressed_next      = pressed_reg;
        count_next        = count_reg;
        sliders_next      = sliders_reg;
        cct_next          = cct_reg;
        prev_count_next   = prev_count_reg;
        press_active_next = press_active_reg;
        long_rep_next     = long_rep_reg;
        press_start_next  = press_start_reg;
        wait_active_next  = wait_active_reg;
        wait_start_next   = wait_start_reg;
        sel_next          = sel_reg;
        held_next         = held_reg;
        e_next            = e_reg;
        inc_next          = inc_reg;
        res_changed_next  = res_changed_reg;
        res_long_next     = res_long_reg;
        res_toggle_next   = res_toggle_reg;
        res_valid_next    = res_valid_reg;
        res_up_next       = res_up_reg;
        res_value_next    = res_value_reg;
        res_held_next     = res_held_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        out_user_next     = out_user_reg;

        alu_req.a     = now_reg;
        alu_req.b     = press_active_reg ? press_start_reg : now_reg;
        alu_req.sub   = 1'b1;
        alu_req.limit = {16'd0, cfg.long_ms};

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next         = s_tuser;
                    now_next         = s_tdata[31:0];
                    pressed_next     = s_tdata[32];
                    count_next       = s_tdata[48:33];
                    sliders_next     = s_tdata[53:49];
                    cct_next         = s_tdata[54];
                    res_changed_next = 1'b0;
                    res_long_next    = 1'b0;
                    res_toggle_next  = 1'b0;
                    res_valid_next   = 1'b0;
                    res_up_next      = 1'b0;
                    res_value_next   = 8'd0;
                    res_held_next    = 1'b0;
                    if (s_tuser)
                    begin
                        prev_count_next = s_tdata[48:33];
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_BTN;
                    end
                end
            end

            // hold time against the long-press threshold
            ST_BTN:
            begin
                if (pressed_reg)
                begin
                    if (!press_active_reg)
                    begin
                        press_start_next = now_reg;
                    end
                    press_active_next = 1'b1;
                    if (alu_rsp.gt)
                    begin
                        res_long_next = !long_rep_reg;
                        long_rep_next = 1'b1;
                    end
                end
                else if (press_active_reg)
                begin
                    wait_active_next = 1'b0;
                    if (!long_rep_reg)
                    begin
                        if (wait_active_reg)
                        begin
                            res_toggle_next = 1'b1;
                        end
                        else
                        begin
                            wait_active_next = 1'b1;
                            wait_start_next  = now_reg;
                        end
                    end
                    long_rep_next     = 1'b0;
                    press_active_next = 1'b0;
                end
                state_next = ST_WAIT;
            end

            // double-press window expiry
            ST_WAIT:
            begin
                alu_req.a     = now_reg;
                alu_req.b     = wait_start_reg;
                alu_req.limit = {16'd0, cfg.window_ms};
                if (wait_active_reg && alu_rsp.gt && !pressed_reg)
                begin
                    wait_active_next = 1'b0;
                    res_changed_next = 1'b1;
                    e_next           = sel_reg + 4'd1;
                    state_next       = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_DELTA;
                end
            end

            // one menu entry tested per cycle
            ST_SEARCH:
            begin
                e_next = e_wrap;
                if (e_taken)
                begin
                    sel_next   = e_wrap;
                    state_next = ST_DELTA;
                end
            end

            // encoder count delta
            ST_DELTA:
            begin
                alu_req.a       = {16'd0, count_reg};
                alu_req.b       = {16'd0, prev_count_reg};
                alu_req.limit   = 32'd0;
                prev_count_next = count_reg;
                inc_next        = !diff[15];
                state_next      = ST_DONE;
                if (diff != 16'd0)
                begin
                    if (slot.valid)
                    begin
                        state_next = ST_STEP;
                    end
                    else if ((sel_reg != ENTRY_PRESET) || preset_step_ok)
                    begin
                        res_valid_next = 1'b1;
                        res_up_next    = !diff[15];
                    end
                end
            end

            // saturating step of the held value
            ST_STEP:
            begin
                alu_req.a      = {24'd0, held_reg[slot.idx]};
                alu_req.b      = {25'd0, amount};
                alu_req.sub    = !inc_reg;
                alu_req.limit  = {24'd0, VALUE_MAX};
                held_next[slot.idx] = step_val;
                res_valid_next = 1'b1;
                res_up_next    = inc_reg;
                res_value_next = step_val;
                res_held_next  = 1'b1;
                state_next     = ST_DONE;
            end

            // load the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_value_reg,
                                      res_valid_reg ? sel_reg : 4'd0,
                                      res_up_reg, res_valid_reg, res_toggle_reg,
                                      res_long_reg, res_changed_reg, sel_reg};
                    out_user_next  = res_held_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prev_count_reg   <= 16'd0;
            press_active_reg <= 1'b0;
            long_rep_reg     <= 1'b0;
            press_start_reg  <= 32'd0;
            wait_active_reg  <= 1'b0;
            wait_start_reg   <= 32'd0;
            sel_reg          <= 4'd0;
            held_reg         <= HELD_INIT;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_count_reg   <= prev_count_next;
            press_active_reg <= press_active_next;
            long_rep_reg     <= long_rep_next;
            press_start_reg  <= press_start_next;
            wait_active_reg  <= wait_active_next;
            wait_start_reg   <= wait_start_next;
            sel_reg          <= sel_next;
            held_reg         <= held_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        now_reg         <= now_next;
        pressed_reg     <= pressed_next;
        count_reg       <= count_next;
        sliders_reg     <= sliders_next;
        cct_reg         <= cct_next;
        e_reg           <= e_next;
        inc_reg         <= inc_next;
        res_changed_reg <= res_changed_next;
        res_long_reg    <= res_long_next;
        res_toggle_reg  <= res_toggle_next;
        res_valid_reg   <= res_valid_next;
        res_up_reg      <= res_up_next;
        res_value_reg   <= res_value_next;
        res_held_reg    <= res_held_next;
        out_data_reg    <= out_data_next;
        out_user_reg    <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};
    assign m_tuser  = out_user_reg;

    // A baseline load goes straight to the result, a poll through the button phase
    `EBMC_ASSERT_NEXT(a_load_path, state_reg == ST_IDLE && s_tvalid,
        (act_reg && state_reg == ST_DONE) || (!act_reg && state_reg == ST_BTN),
        "accepted item took the wrong path")
    // The selected entry never leaves the menu
    `EBMC_ASSERT_NOW(a_sel_range, 1'b1, sel_reg <= LAST_ENTRY,
        "selected entry out of range")
    // A held value only comes with a step
    `EBMC_ASSERT_NOW(a_held_step, m_tvalid && m_tuser, m_tdata[7] == 1'b1,
        "value_held without adjust_valid")
    // Without a step all step fields are zero
    `EBMC_ASSERT_NOW(a_no_step, m_tvalid && !m_tdata[7],
        m_tdata[20:8] == 13'd0 && !m_tuser, "step fields set without a step")
    // The search cursor stays within one past the last entry
    `EBMC_ASSERT_NOW(a_search_cursor, state_reg == ST_SEARCH, e_reg <= LAST_ENTRY + 4'd1,
        "menu search cursor out of range")

endmodule
